[src/spid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spid_pkg: shared types and constants
// Register map codes and the request/response records of the serial units.
// ----------------------------------------------------------------------------
package spid_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TOLERANCE   = 115;

    localparam logic [2:0] REG_FILTER_GAIN = 3'd0;
    localparam logic [2:0] REG_LEFT_LIMIT  = 3'd1;
    localparam logic [2:0] REG_RIGHT_LIMIT = 3'd2;
    localparam logic [2:0] REG_ANGLE_LIMIT = 3'd3;
    localparam logic [2:0] REG_GAIN_P      = 3'd4;
    localparam logic [2:0] REG_GAIN_I      = 3'd5;
    localparam logic [2:0] REG_GAIN_D      = 3'd6;
    localparam logic [2:0] REG_POWER_LIMIT = 3'd7;

    localparam logic signed [63:0] I_TERM_SAT = 64'sh2000_0000_0000_0000;

    typedef struct packed {
        logic               start;
        logic signed [48:0] a;
        logic [31:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [50:0] num;
        logic [12:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [50:0] q;
    } div_rsp_t;

endpackage
`default_nettype wire

[src/spid_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spid_mul: bit-serial multiplier
// Signed by unsigned, one multiplier bit per cycle, MSB first, saturating
// at the integral-term limit.
// ----------------------------------------------------------------------------
module spid_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spid_pkg::mul_req_t req,
    output spid_pkg::mul_rsp_t      rsp
);
    import spid_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sat_reg, sat_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [48:0] a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic signed [63:0] acc_reg, acc_next;

    always_comb begin
        logic signed [63:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        trial     = (acc_reg <<< 1) + (b_reg[cnt_reg] ? 64'(a_reg) : 64'sd0);
        if (req.start) begin
            busy_next = 1'b1;
            sat_next  = 1'b0;
            cnt_next  = 5'd31;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            // freeze once past the limit: the Horner sum only grows from there
            if (!sat_reg) begin
                if (trial > I_TERM_SAT) sat_next = 1'b1;
                else acc_next = trial;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = sat_reg ? I_TERM_SAT : acc_reg;

endmodule
`default_nettype wire

[src/spid_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spid_div: bit-serial restoring divider
// Unsigned quotient, one bit per cycle, numerator shifted out MSB first.
// ----------------------------------------------------------------------------
module spid_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spid_pkg::div_req_t req,
    output spid_pkg::div_rsp_t      rsp
);
    import spid_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [50:0] nq_reg, nq_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] den_reg, den_next;

    always_comb begin
        logic [13:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, nq_reg[50]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd50;
            nq_next   = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = 13'(trial - {1'b0, den_reg});
                nq_next  = {nq_reg[49:0], 1'b1};
            end else begin
                rem_next = trial[12:0];
                nq_next  = {nq_reg[49:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = nq_reg;

endmodule
`default_nettype wire

[src/steering_pid_with_prefilter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a request runs six 32-bit serial multiplies, two 51-bit serial divides,
//   an error state and a finish state before its result is registered.
//   Equal pot limits or zero elapsed time each skip a multiply and a divide.
// Flow: a new request is taken only when the sequencer is idle, and the finish
//   state holds while the last result is unread.
// Reset: synchronous active-low; registers take defaults, filter/integral/previous error clear.
// ----------------------------------------------------------------------------
// steering_pid_with_prefilter_unit: steering position controller
// IIR-filtered pot sample mapped to an angle, setpoint by mode, PID effort
// clamped and gated by a deadband into direction and drive level.
// ----------------------------------------------------------------------------
module steering_pid_with_prefilter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: pot_sample[11:0], elapsed_ms[21:12], command_angle[37:22],
    //        radio_angle[53:38], zero fill [55:54]
    input  wire logic [55:0] s_tdata,
    // tuser: steer_mode[1:0], link_ok[2], command_ok[3]
    input  wire logic [3:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: measured_angle[15:0], angle_error[32:16], effort[41:33],
    //        drive_level[49:42], zero fill [55:50]
    output logic [55:0]      m_tdata,
    // tuser: steer_left[0], drive_update[1]
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import spid_pkg::*;

    // sequencer codes: each unit step has a launch state and a wait state
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_F_GO  = 5'd1;
    localparam logic [4:0] ST_F_WT  = 5'd2;
    localparam logic [4:0] ST_M_GO  = 5'd3;
    localparam logic [4:0] ST_M_WT  = 5'd4;
    localparam logic [4:0] ST_MD_GO = 5'd5;
    localparam logic [4:0] ST_MD_WT = 5'd6;
    localparam logic [4:0] ST_ERR   = 5'd7;
    localparam logic [4:0] ST_N_GO  = 5'd8;
    localparam logic [4:0] ST_N_WT  = 5'd9;
    localparam logic [4:0] ST_P_GO  = 5'd10;
    localparam logic [4:0] ST_P_WT  = 5'd11;
    localparam logic [4:0] ST_D_GO  = 5'd12;
    localparam logic [4:0] ST_D_WT  = 5'd13;
    localparam logic [4:0] ST_DD_GO = 5'd14;
    localparam logic [4:0] ST_DD_WT = 5'd15;
    localparam logic [4:0] ST_I_GO  = 5'd16;
    localparam logic [4:0] ST_I_WT  = 5'd17;
    localparam logic [4:0] ST_FIN   = 5'd18;

    localparam logic signed [49:0] INT_MAX48 = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] INT_MIN48 = -50'sh0_8000_0000_0000;
    localparam logic signed [16:0] TOL17     = 17'(TOLERANCE);

    // configuration registers
    logic [15:0] gain_f_reg;
    logic [11:0] left_reg;
    logic [11:0] right_reg;
    logic [14:0] alim_reg;
    logic [31:0] gp_reg, gi_reg, gd_reg;
    logic [7:0]  plim_reg;

    // latched request fields
    logic [SAMPLE_BITS-1:0] pot_reg;
    logic [9:0]             el_reg;
    logic [1:0]             mode_reg;
    logic                   link_reg, cmdok_reg;
    logic signed [15:0]     cang_reg, rang_reg;

    // controller state
    logic [SAMPLE_BITS+7:0] fp_reg, fp_next;
    logic signed [47:0]     integ_reg, integ_next;
    logic signed [16:0]     prev_reg, prev_next;

    // working registers
    logic [4:0]         state_reg, state_next;
    logic [12:0]        rd_reg, rd_next;
    logic signed [15:0] angle_reg, angle_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [63:0] pd_reg, pd_next;
    logic signed [63:0] it_reg, it_next;
    logic               neg_reg, neg_next;

    // result holding register
    logic        ov_reg, ov_next;
    logic [55:0] od_reg, od_next;
    logic [1:0]  ou_reg, ou_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    logic in_acc, cfg_wr;
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    spid_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    spid_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // shared unit operand steering
    always_comb begin
        logic signed [20:0] fdiff;
        logic signed [13:0] mdiff;
        logic signed [17:0] ddiff;
        logic signed [48:0] iw;
        logic signed [12:0] lr;
        logic signed [63:0] ap;
        logic [12:0]        ad;
        fdiff = $signed({1'b0, pot_reg, 8'b0}) - $signed({1'b0, fp_reg});
        mdiff = $signed({1'b0, rd_reg}) - $signed({2'b0, left_reg});
        ddiff = 18'(err_reg) - 18'(prev_reg);
        iw    = 49'(integ_reg);
        lr    = $signed({1'b0, left_reg}) - $signed({1'b0, right_reg});
        ad    = lr[12] ? 13'(-lr) : 13'(lr);
        mreq.start = 1'b0;
        mreq.a     = '0;
        mreq.b     = '0;
        case (state_reg)
            ST_F_GO: begin
                mreq.start = 1'b1;
                mreq.a     = 49'(fdiff);
                mreq.b     = {16'b0, gain_f_reg};
            end
            ST_M_GO: begin
                mreq.start = 1'b1;
                mreq.a     = 49'(mdiff);
                mreq.b     = {16'b0, alim_reg, 1'b0};
            end
            ST_N_GO: begin
                mreq.start = 1'b1;
                mreq.a     = 49'(err_reg);
                mreq.b     = {22'b0, el_reg};
            end
            ST_P_GO: begin
                mreq.start = 1'b1;
                mreq.a     = 49'(err_reg);
                mreq.b     = gp_reg;
            end
            ST_D_GO: begin
                mreq.start = 1'b1;
                mreq.a     = 49'(ddiff);
                mreq.b     = gd_reg;
            end
            ST_I_GO: begin
                mreq.start = 1'b1;
                mreq.a     = iw[48] ? -iw : iw;
                mreq.b     = gi_reg;
            end
            default: begin
                mreq.start = 1'b0;
            end
        endcase
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        ap         = '0;
        case (state_reg)
            ST_MD_GO: begin
                // round half away from zero: add half the divisor to |num|
                ap         = pd_reg[63] ? -pd_reg : pd_reg;
                dreq.start = 1'b1;
                dreq.num   = ap[50:0] + {39'b0, ad[12:1]};
                dreq.den   = ad;
            end
            ST_DD_GO: begin
                ap         = it_reg[63] ? -it_reg : it_reg;
                dreq.start = 1'b1;
                dreq.num   = ap[50:0];
                dreq.den   = {3'b0, el_reg};
            end
            default: begin
                dreq.start = 1'b0;
            end
        endcase
    end

    // sequencer and datapath
    always_comb begin
        logic signed [63:0] fsum;
        logic [20:0]        rsum;
        logic signed [33:0] qs, ang;
        logic signed [15:0] sp;
        logic signed [49:0] isum;
        logic signed [63:0] s, sa;
        logic [33:0]        smag;
        logic [7:0]         mag;
        logic signed [8:0]  eff;
        logic               sl, upd;
        logic [7:0]         lvl;
        state_next = state_reg;
        fp_next    = fp_reg;
        integ_next = integ_reg;
        prev_next  = prev_reg;
        rd_next    = rd_reg;
        angle_next = angle_reg;
        err_next   = err_reg;
        pd_next    = pd_reg;
        it_next    = it_reg;
        neg_next   = neg_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;
        fsum = $signed({28'b0, fp_reg, 16'b0}) + mrsp.p + 64'sd32768;
        rsum = {1'b0, fsum[35:16]} + 21'd128;
        qs   = neg_reg ? -$signed({1'b0, drsp.q[32:0]}) : $signed({1'b0, drsp.q[32:0]});
        ang  = $signed({19'b0, alim_reg}) + qs;
        if (mode_reg == 2'd2 && link_reg && cmdok_reg) sp = cang_reg;
        else if (mode_reg == 2'd1 && link_reg) sp = rang_reg;
        else sp = '0;
        isum = 50'(integ_reg) + 50'(mrsp.p[49:0]);
        s    = pd_reg + it_reg;
        sa   = s[63] ? -s : s;
        smag = 34'(sa[63:30]);
        mag  = (smag > {26'b0, plim_reg}) ? plim_reg : smag[7:0];
        eff  = s[63] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        sl   = 1'b0;
        upd  = 1'b0;
        lvl  = '0;
        if (err_reg > TOL17) begin
            upd = 1'b1;
            lvl = s[63] ? 8'd0 : mag;
        end else if (err_reg < -TOL17) begin
            sl  = 1'b1;
            upd = 1'b1;
            lvl = mag;
        end else begin
            eff = '0;
        end
        if (m_tvalid && m_tready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = ST_F_GO;
            end
            ST_F_GO:  state_next = ST_F_WT;
            ST_F_WT: begin
                if (mrsp.done) begin
                    fp_next = fsum[35:16];
                    rd_next = rsum[20:8];
                    if (left_reg == right_reg) begin
                        angle_next = '0;
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_M_GO;
                    end
                end
            end
            ST_M_GO:  state_next = ST_M_WT;
            ST_M_WT: begin
                if (mrsp.done) begin
                    pd_next    = mrsp.p;
                    neg_next   = mrsp.p[63] ^ (left_reg < right_reg);
                    state_next = ST_MD_GO;
                end
            end
            ST_MD_GO: state_next = ST_MD_WT;
            ST_MD_WT: begin
                if (drsp.done) begin
                    // saturate the mapped angle to 16-bit signed
                    if (ang > 34'sd32767) angle_next = 16'sh7FFF;
                    else if (ang < -34'sd32768) angle_next = -16'sh8000;
                    else angle_next = ang[15:0];
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = 17'(sp) - 17'(angle_reg);
                state_next = ST_N_GO;
            end
            ST_N_GO:  state_next = ST_N_WT;
            ST_N_WT: begin
                if (mrsp.done) begin
                    if (isum > INT_MAX48) integ_next = INT_MAX48[47:0];
                    else if (isum < INT_MIN48) integ_next = INT_MIN48[47:0];
                    else integ_next = isum[47:0];
                    state_next = ST_P_GO;
                end
            end
            ST_P_GO:  state_next = ST_P_WT;
            ST_P_WT: begin
                if (mrsp.done) begin
                    pd_next    = mrsp.p;
                    // zero elapsed time: skip the derivative term
                    state_next = (el_reg != 10'd0) ? ST_D_GO : ST_I_GO;
                end
            end
            ST_D_GO:  state_next = ST_D_WT;
            ST_D_WT: begin
                if (mrsp.done) begin
                    it_next    = mrsp.p;
                    neg_next   = mrsp.p[63];
                    state_next = ST_DD_GO;
                end
            end
            ST_DD_GO: state_next = ST_DD_WT;
            ST_DD_WT: begin
                if (drsp.done) begin
                    pd_next    = pd_reg + (neg_reg ? -$signed({13'b0, drsp.q})
                                                   : $signed({13'b0, drsp.q}));
                    state_next = ST_I_GO;
                end
            end
            ST_I_GO:  state_next = ST_I_WT;
            ST_I_WT: begin
                if (mrsp.done) begin
                    it_next    = integ_reg[47] ? -mrsp.p : mrsp.p;
                    prev_next  = err_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_tvalid || m_tready) begin
                    ov_next    = 1'b1;
                    od_next    = {6'b0, lvl, eff, err_reg, angle_reg};
                    ou_next    = {upd, sl};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ov_reg     <= 1'b0;
            fp_reg     <= '0;
            integ_reg  <= '0;
            prev_reg   <= '0;
            gain_f_reg <= 16'd6554;
            left_reg   <= 12'd3460;
            right_reg  <= 12'd768;
            alim_reg   <= 15'd11960;
            gp_reg     <= 32'd18350080;
            gi_reg     <= 32'd0;
            gd_reg     <= 32'd0;
            plim_reg   <= 8'd150;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            fp_reg    <= fp_next;
            integ_reg <= integ_next;
            prev_reg  <= prev_next;
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_FILTER_GAIN: gain_f_reg <= pwdata[15:0];
                    REG_LEFT_LIMIT:  left_reg   <= pwdata[11:0];
                    REG_RIGHT_LIMIT: right_reg  <= pwdata[11:0];
                    REG_ANGLE_LIMIT: alim_reg   <= pwdata[14:0];
                    REG_GAIN_P:      gp_reg     <= pwdata;
                    REG_GAIN_I:      gi_reg     <= pwdata;
                    REG_GAIN_D:      gd_reg     <= pwdata;
                    REG_POWER_LIMIT: plim_reg   <= pwdata[7:0];
                    default:         plim_reg   <= plim_reg;
                endcase
            end
        end
        if (in_acc) begin
            pot_reg   <= s_tdata[11:0];
            el_reg    <= s_tdata[21:12];
            cang_reg  <= s_tdata[37:22];
            rang_reg  <= s_tdata[53:38];
            mode_reg  <= s_tuser[1:0];
            link_reg  <= s_tuser[2];
            cmdok_reg <= s_tuser[3];
        end
        rd_reg    <= rd_next;
        angle_reg <= angle_next;
        err_reg   <= err_next;
        pd_reg    <= pd_next;
        it_reg    <= it_next;
        neg_reg   <= neg_next;
        od_reg    <= od_next;
        ou_reg    <= ou_next;
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_FILTER_GAIN: prdata = {16'b0, gain_f_reg};
            REG_LEFT_LIMIT:  prdata = {20'b0, left_reg};
            REG_RIGHT_LIMIT: prdata = {20'b0, right_reg};
            REG_ANGLE_LIMIT: prdata = {17'b0, alim_reg};
            REG_GAIN_P:      prdata = gp_reg;
            REG_GAIN_I:      prdata = gi_reg;
            REG_GAIN_D:      prdata = gd_reg;
            REG_POWER_LIMIT: prdata = {24'b0, plim_reg};
            default:         prdata = '0;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

endmodule
`default_nettype wire

[src/spid_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spid_checker: port-level checks
// Result consistency and request sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module spid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[49:33] == 17'd0 && !m_tuser[0])
        else $error("deadband result not quiet");

    a_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] && !m_tuser[0] && !m_tdata[41]
            |-> m_tdata[49:42] == m_tdata[40:33])
        else $error("right drive level mismatch");

endmodule

bind steering_pid_with_prefilter_unit spid_checker u_spid_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
);
`default_nettype wire
